// ===== hdl/orm_pkg.sv =====
// Package: payload types and status codes for the online range minimum block.
`timescale 1ns / 1ps
package orm_pkg;
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned VAL_BITS   = 31;
  localparam int unsigned COUNT_BITS = 11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_RANGE = 2'd2
  } status_t;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [VAL_BITS-1:0]   value;
    logic [INDEX_BITS-1:0] left_index;
    logic [INDEX_BITS-1:0] right_index;
  } in_item_t;

  typedef struct packed {
    logic [VAL_BITS-1:0]   min_value;
    status_t               status;
    logic [COUNT_BITS-1:0] stored_count;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;
    logic [VAL_BITS-1:0]   wdata;
    logic [INDEX_BITS-1:0] raddr;
  } mem_req_t;
endpackage

// ===== hdl/orm_store.sv =====
// Value store: single-port-write, registered-read memory.
`timescale 1ns / 1ps
module orm_store (
  input  logic               clk,
  input  orm_pkg::mem_req_t  req,
  output logic [orm_pkg::VAL_BITS-1:0] rdata
);
  import orm_pkg::*;
  logic [VAL_BITS-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== hdl/online_range_minimum_query.sv =====
// Top level: append-only value store answering range minimum queries.
`timescale 1ns / 1ps
// An append, a full append or a bad range has its result registered at the
// accepting edge. A valid query scans the stored range one entry per cycle
// through the value memory read port in S_SCAN and S_LAST and registers its
// result in S_DONE. One transaction is in work at a time; a result waiting
// in the output register holds off the next transaction until it is taken.
module online_range_minimum_query (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  orm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output orm_pkg::out_item_t out_data
);
  import orm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  logic [COUNT_BITS-1:0] count;
  logic [INDEX_BITS-1:0] addr;
  logic [INDEX_BITS-1:0] hi;
  logic [VAL_BITS-1:0]   best;
  logic                  first;
  logic [VAL_BITS-1:0]   rdata;
  mem_req_t              req;
  logic                  take;
  logic                  bad;
  logic                  full;
  logic                  out_load;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;
  assign full     = (count >= COUNT_BITS'(CAPACITY));
  assign bad      = (in_data.left_index > in_data.right_index) ||
                    ({1'b0, in_data.right_index} >= count);
  assign out_load = (take && ((in_data.op == OP_APPEND) || bad)) || (state == S_DONE);

  always_comb begin
    req.we    = take && (in_data.op == OP_APPEND) && !full;
    req.waddr = count[INDEX_BITS-1:0];
    req.wdata = in_data.value;
    req.raddr = (state == S_IDLE) ? in_data.left_index : addr;
  end

  orm_store u_store (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (in_data.op == OP_APPEND) begin
              out_data.min_value    <= '0;
              out_data.status       <= full ? ST_FULL : ST_OK;
              out_data.stored_count <= full ? count : count + 1'b1;
              if (!full) begin
                count <= count + 1'b1;
              end
            end else if (bad) begin
              out_data.min_value    <= '0;
              out_data.status       <= ST_BAD_RANGE;
              out_data.stored_count <= count;
            end else begin
              addr  <= in_data.left_index + 1'b1;
              hi    <= in_data.right_index;
              first <= 1'b1;
              state <= (in_data.left_index == in_data.right_index) ? S_LAST : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          first <= 1'b0;
          if (first || rdata < best) begin
            best <= rdata;
          end
          if (addr == hi) begin
            state <= S_LAST;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_LAST: begin
          if (first || rdata < best) begin
            best <= rdata;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          out_data.min_value    <= best;
          out_data.status       <= ST_OK;
          out_data.stored_count <= count;
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// Testbench for the online range minimum block: directed and random appends and queries.
`timescale 1ns / 1ps
module tb_top;
  import orm_pkg::*;

  localparam int CAP = CAPACITY;

  class minimum_scoreboard;
    logic [VAL_BITS-1:0] values[CAP];
    int unsigned count;
    out_item_t expected_q[$];
    int errors;
    int checked;

    function void clear();
      count = 0;
      expected_q.delete();
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    function void note_input(in_item_t it);
      out_item_t r;
      logic [VAL_BITS-1:0] best;
      r.min_value = '0;
      r.status = ST_OK;
      if (it.op == OP_APPEND) begin
        if (count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          values[count] = it.value;
          count++;
        end
      end else begin
        if (it.left_index > it.right_index || it.right_index >= count) begin
          r.status = ST_BAD_RANGE;
        end else begin
          best = values[it.left_index];
          for (int k = it.left_index + 1; k <= it.right_index; k++)
            if (values[k] < best) best = values[k];
          r.min_value = best;
        end
      end
      r.stored_count = count[COUNT_BITS-1:0];
      expected_q = {expected_q, r};
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = expected_q.pop_front();
      if (got.min_value !== e.min_value)
        report($sformatf("min_value got %h want %h", got.min_value, e.min_value));
      if (got.status !== e.status)
        report($sformatf("status got %0d want %0d", got.status, e.status));
      if (got.stored_count !== e.stored_count)
        report($sformatf("stored_count got %0d want %0d", got.stored_count,
                         e.stored_count));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;

  minimum_scoreboard sb;
  int cycles = 0;
  int hold_off = 0;
  bit stall_enable = 1;
  int n_app = 0, n_query = 0;

  always #4 clk = ~clk;

  online_range_minimum_query i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (!rst && in_valid && in_ready) begin
      sb.note_input(in_data);
      if (in_data.op == OP_APPEND) n_app++; else n_query++;
    end
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (cycles > 10000000) begin
      $display("Timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: own stall pattern, plus long hold-offs
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 0;
    end else if (!stall_enable) begin
      out_ready <= 1;
    end else begin
      out_ready <= (cycles % 7 < 5) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 1);
    end
  end

  // valid stays high after acceptance; the caller drops it
  task automatic send(in_item_t it);
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_burst_item(in_item_t it, ref int burst);
    if (burst == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst = $urandom_range(1, 20);
    end
    burst--;
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t mk(logic op, int unsigned v, int l, int r);
    in_item_t it;
    it.op = op;
    it.value = v[VAL_BITS-1:0];
    it.left_index = l[9:0];
    it.right_index = r[9:0];
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int c, l, r;
    it = mk(OP_QUERY, $urandom, $urandom, $urandom);
    c = sb.count;
    if ($urandom_range(0, 99) < 45) begin
      it.op = OP_APPEND;
      case ($urandom_range(0, 3))
        0: it.value = VAL_BITS'($urandom_range(0, 15));
        1: it.value = VAL_BITS'(32'h7fffffff - $urandom_range(0, 3));
        default: it.value = VAL_BITS'($urandom);
      endcase
    end else if (c > 0 && $urandom_range(0, 9) < 8) begin
      r = $urandom_range(0, c - 1);
      l = ($urandom_range(0, 1)) ? (r - $urandom_range(0, (r < 12) ? r : 12)) : $urandom_range(0, r);
      it.left_index = l[9:0];
      it.right_index = r[9:0];
    end
    return it;
  endfunction

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int burst;
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty store, extremes, bad ranges
    send(mk(OP_QUERY, 0, 0, 0));
    send(mk(OP_APPEND, 31'h7fffffff, 1023, 1023));
    send(mk(OP_APPEND, 0, 0, 0));
    send(mk(OP_APPEND, 5, 0, 0));
    send(mk(OP_APPEND, 5, 0, 0));
    send(mk(OP_QUERY, 0, 0, 0));
    send(mk(OP_QUERY, 0, 0, 3));
    send(mk(OP_QUERY, 0, 2, 3));
    send(mk(OP_QUERY, 0, 3, 2));
    send(mk(OP_QUERY, 0, 0, 4));
    send(mk(OP_QUERY, 31'h7fffffff, 1023, 1023));
    send(mk(OP_QUERY, 0, 1023, 0));
    send(mk(OP_QUERY, 0, 3, 3));
    in_valid <= 0;
    drain();

    // random phase with bursts and stalls
    burst = 0;
    for (int i = 0; i < 150; i++) begin
      if (i == 60) hold_off = 400;
      send_burst_item(rand_item(), burst);
    end
    in_valid <= 0;
    drain();

    // fill to capacity, then full appends and wide queries
    stall_enable = 0;
    while (sb.count < CAP) send(mk(OP_APPEND, $urandom, $urandom, $urandom));
    stall_enable = 1;
    burst = 0;
    for (int i = 0; i < 12; i++)
      send_burst_item(mk(OP_APPEND, $urandom, 0, 0), burst);
    send_burst_item(mk(OP_QUERY, 0, 0, 1023), burst);
    send_burst_item(mk(OP_QUERY, 0, 1023, 1023), burst);
    for (int i = 0; i < 40; i++) send_burst_item(rand_item(), burst);
    in_valid <= 0;
    drain();
    repeat (2000) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.report("results missing at end of run");

    $display("Covered %0d appends and %0d queries, %0d results checked, store filled to %0d.",
             n_app, n_query, sb.checked, sb.count);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/orm_pkg.sv
hdl/orm_store.sv
hdl/online_range_minimum_query.sv
verif/tb_top.sv
